[hdl/efra_pkg.sv]
`timescale 1ns / 1ps

package efra_pkg;

  localparam int unsigned ROOMS_DEF     = 16;
  localparam int unsigned TIME_BITS_DEF = 40;

  localparam int unsigned CFG_W      = 5;
  localparam int unsigned IN_TIME_W  = 32;
  localparam int unsigned ROOM_OUT_W = 4;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned QDEPTH     = 2;

  localparam logic [CFG_W-1:0]   ROOMS_RESET = CFG_W'(16);
  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

  typedef struct packed {
    logic [IN_TIME_W-1:0] start_time;
    logic [IN_TIME_W-1:0] end_time;
    logic [IN_TIME_W-1:0] duration;
    logic                 final_meeting;
    logic [CFG_W-1:0]     rooms;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } queue_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_e;

endpackage

[hdl/efra_req_if.sv]
`timescale 1ns / 1ps

interface efra_req_if;
  import efra_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [IN_TIME_W-1:0] start_time;
  logic [IN_TIME_W-1:0] end_time;
  logic                 final_meeting;

  modport source (output valid, output start_time, output end_time, output final_meeting,
                  input ready);
  modport sink   (input valid, input start_time, input end_time, input final_meeting,
                  output ready);
endinterface

[hdl/efra_rsp_if.sv]
`timescale 1ns / 1ps

interface efra_rsp_if;
  import efra_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [ROOM_OUT_W-1:0] assigned_room;
  logic                  was_delayed;
  logic [ROOM_OUT_W-1:0] most_booked_room;
  logic                  batch_done;

  modport source (output valid, output assigned_room, output was_delayed,
                  output most_booked_room, output batch_done, input ready);
  modport sink   (input valid, input assigned_room, input was_delayed,
                  input most_booked_room, input batch_done, output ready);
endinterface

[hdl/efra_queue.sv]
`timescale 1ns / 1ps

module efra_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  efra_pkg::job_t    push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output efra_pkg::queue_out_t head_o
);
  import efra_pkg::*;

  localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  job_t             slot_q [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o       = (cnt_q == CNT_W'(QDEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.job   = slot_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(QDEPTH))
    else $error("queue count above depth");

endmodule

[hdl/efra_front.sv]
`timescale 1ns / 1ps

module efra_front #(
  parameter int unsigned ROOMS = efra_pkg::ROOMS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [efra_pkg::CFG_W-1:0]  rooms_in_use_i,
  efra_req_if.sink                    req_i,
  input  logic                        pop_i,
  output efra_pkg::queue_out_t        head_o
);
  import efra_pkg::*;

  localparam logic [7:0] ROOMS_W8 = 8'(ROOMS);

  job_t job;
  logic full;

  // Classify: clamp room count, precompute delay duration.
  always_comb begin
    job.start_time    = req_i.start_time;
    job.end_time      = req_i.end_time;
    job.final_meeting = req_i.final_meeting;
    job.duration      = (req_i.end_time > req_i.start_time)
                        ? (req_i.end_time - req_i.start_time) : '0;
    if (rooms_in_use_i == '0) begin
      job.rooms = CFG_W'(1);
    end else if ({3'b000, rooms_in_use_i} > ROOMS_W8) begin
      job.rooms = CFG_W'(ROOMS);
    end else begin
      job.rooms = rooms_in_use_i;
    end
  end

  assign req_i.ready = !full;

  efra_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (req_i.valid),
    .push_data_i (job),
    .full_o      (full),
    .pop_i       (pop_i),
    .head_o      (head_o)
  );

endmodule

[hdl/efra_back.sv]
`timescale 1ns / 1ps

module efra_back #(
  parameter int unsigned ROOMS     = efra_pkg::ROOMS_DEF,
  parameter int unsigned TIME_BITS = efra_pkg::TIME_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  efra_pkg::queue_out_t head_i,
  output logic                 pop_o,
  efra_rsp_if.source           rsp_o
);
  import efra_pkg::*;

  localparam int unsigned RIDX_W = (ROOMS > 1) ? $clog2(ROOMS) : 1;
  localparam int unsigned CNT_W  = $clog2(ROOMS + 1);
  localparam int unsigned CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int unsigned EXT_W  = (RIDX_W > ROOM_OUT_W) ? RIDX_W : ROOM_OUT_W;

  logic [TIME_BITS-1:0] time_mem [ROOMS];
  logic [COUNT_W-1:0]   book_mem [ROOMS];

  state_e               state_q, state_d;
  job_t                 job_q;
  logic [CNT_W-1:0]     issue_q;
  logic                 cmp_vld_q;
  logic [RIDX_W-1:0]    cmp_idx_q;
  logic [TIME_BITS-1:0] rd_time_q;
  logic [COUNT_W-1:0]   rd_book_q;
  logic [ROOMS-1:0]     vld_q;
  logic                 found_q;
  logic [RIDX_W-1:0]    min_room_q;
  logic [TIME_BITS-1:0] min_time_q;
  logic [COUNT_W-1:0]   min_book_q;
  logic [RIDX_W-1:0]    best_room_q;
  logic [COUNT_W-1:0]   best_cnt_q;
  logic                 out_vld_q;
  logic [ROOM_OUT_W-1:0] out_room_q, out_best_q;
  logic                 out_delayed_q, out_done_q;

  logic                 issue_lt_n, issue_en, scan_hit, scan_end, upd_go;
  logic [RIDX_W-1:0]    rd_addr;
  logic [TIME_BITS-1:0] eff_time;
  logic [COUNT_W-1:0]   eff_book;
  logic [TIME_BITS:0]   delay_sum;
  logic [TIME_BITS-1:0] new_time;
  logic [COUNT_W-1:0]   new_book;
  logic                 better;
  logic [RIDX_W-1:0]    best_room_nx;
  logic [EXT_W-1:0]     room_ext, best_ext;

  assign issue_lt_n = CMP_W'(issue_q) < CMP_W'(job_q.rooms);
  assign rd_addr    = issue_q[RIDX_W-1:0];
  assign eff_time   = vld_q[cmp_idx_q] ? rd_time_q : '0;
  assign eff_book   = vld_q[cmp_idx_q] ? rd_book_q : '0;
  assign scan_hit   = (state_q == ST_SCAN) && cmp_vld_q
                      && (eff_time <= TIME_BITS'(job_q.start_time));
  assign scan_end   = (state_q == ST_SCAN) && !issue_lt_n && !scan_hit;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (head_i.valid) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_hit || scan_end) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (upd_go) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = 1'b0;
    issue_en = 1'b0;
    upd_go   = 1'b0;
    case (state_q)
      ST_IDLE:   pop_o    = head_i.valid;
      ST_SCAN:   issue_en = issue_lt_n;
      ST_UPDATE: upd_go   = !out_vld_q || rsp_o.ready;
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  // Update arithmetic
  assign delay_sum = {1'b0, min_time_q} + (TIME_BITS + 1)'(job_q.duration);
  assign new_time  = found_q ? TIME_BITS'(job_q.end_time)
                   : (delay_sum[TIME_BITS] ? '1 : delay_sum[TIME_BITS-1:0]);
  assign new_book  = (min_book_q == COUNT_MAX) ? min_book_q : min_book_q + COUNT_W'(1);
  assign better    = (new_book > best_cnt_q)
                     || ((new_book == best_cnt_q) && (min_room_q < best_room_q));
  assign best_room_nx = better ? min_room_q : best_room_q;
  assign room_ext  = EXT_W'(min_room_q);
  assign best_ext  = EXT_W'(best_room_nx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issue_q     <= '0;
      cmp_vld_q   <= 1'b0;
      vld_q       <= '0;
      found_q     <= 1'b0;
      best_room_q <= '0;
      best_cnt_q  <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= issue_en && !scan_hit;
      if (pop_o) begin
        issue_q <= '0;
        found_q <= 1'b0;
      end else if (issue_en) begin
        issue_q <= issue_q + CNT_W'(1);
      end
      if (scan_hit) begin
        found_q <= 1'b1;
      end
      if (upd_go) begin
        out_vld_q <= 1'b1;
        if (job_q.final_meeting) begin
          vld_q       <= '0;
          best_room_q <= '0;
          best_cnt_q  <= '0;
        end else begin
          vld_q[min_room_q] <= 1'b1;
          if (better) begin
            best_room_q <= min_room_q;
            best_cnt_q  <= new_book;
          end
        end
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= head_i.job;
    end
    cmp_idx_q <= rd_addr;
    rd_time_q <= time_mem[rd_addr];
    rd_book_q <= book_mem[rd_addr];
    if (scan_hit) begin
      min_room_q <= cmp_idx_q;
      min_book_q <= eff_book;
    end else if ((state_q == ST_SCAN) && cmp_vld_q
                 && ((cmp_idx_q == '0) || (eff_time < min_time_q))) begin
      min_room_q <= cmp_idx_q;
      min_time_q <= eff_time;
      min_book_q <= eff_book;
    end
    if (upd_go) begin
      time_mem[min_room_q] <= new_time;
      book_mem[min_room_q] <= new_book;
      out_room_q    <= room_ext[ROOM_OUT_W-1:0];
      out_best_q    <= best_ext[ROOM_OUT_W-1:0];
      out_delayed_q <= !found_q;
      out_done_q    <= job_q.final_meeting;
    end
  end

  assign rsp_o.valid            = out_vld_q;
  assign rsp_o.assigned_room    = out_room_q;
  assign rsp_o.was_delayed      = out_delayed_q;
  assign rsp_o.most_booked_room = out_best_q;
  assign rsp_o.batch_done       = out_done_q;

  a_cmp_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> (CMP_W'(cmp_idx_q) < CMP_W'(job_q.rooms)))
    else $error("compared room outside rooms in use");

  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_go && job_q.final_meeting) |=> ((vld_q == '0) && (best_cnt_q == '0)))
    else $error("state not cleared after final request");

  a_update_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_go |=> (out_vld_q && (state_q == ST_IDLE)))
    else $error("update did not produce a result");

endmodule

[hdl/earliest_free_room_allocator_unit.sv]
`timescale 1ns / 1ps
// A request waits in the front queue, is popped in IDLE, then the back end scans
// rooms 0..n-1 (n = rooms in use, clamped to 1..ROOMS) up to the first free room.
// The scan reads one room per cycle over the free-time memory read port, and
// the back end takes one request at a time. Up to 2 requests queue in front.
// Reset: asynchronous, active low; all rooms free, counts zero, rooms_in_use 16.
module earliest_free_room_allocator_unit #(
  parameter int unsigned ROOMS     = efra_pkg::ROOMS_DEF,
  parameter int unsigned TIME_BITS = efra_pkg::TIME_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [efra_pkg::CFG_W-1:0] cfg_wdata_i,
  efra_req_if.sink                   req_i,
  efra_rsp_if.source                 rsp_o
);
  import efra_pkg::*;

  logic [CFG_W-1:0] rooms_q;
  queue_out_t       head;
  logic             pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rooms_q <= ROOMS_RESET;
    end else if (cfg_we_i) begin
      rooms_q <= cfg_wdata_i;
    end
  end

  efra_front #(
    .ROOMS (ROOMS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rooms_in_use_i (rooms_q),
    .req_i          (req_i),
    .pop_i          (pop),
    .head_o         (head)
  );

  efra_back #(
    .ROOMS     (ROOMS),
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .rsp_o  (rsp_o)
  );

endmodule
